// File: design/websocket_frame_receiver_unit_defines.svh
// ----------------------------------------------------------------------------
// websocket_frame_receiver_unit_defines.svh
// Assertion macros shared by the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_UNIT_DEFINES_SVH

// clocked check, disabled during reset
`define WSFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wsfr: check failed");

// same, with a message of its own
`define WSFR_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// File: design/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants of the WebSocket frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_LENHI   = 3'd2,
        PH_LENLO   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    localparam logic [1:0] KIND_DATA       = 2'd0;
    localparam logic [1:0] KIND_PONG       = 2'd1;
    localparam logic [1:0] KIND_PONG_EMPTY = 2'd2;
    localparam logic [1:0] KIND_CLOSE      = 2'd3;

    localparam logic [6:0] OP_CONT   = 7'h00;
    localparam logic [6:0] OP_TEXT   = 7'h01;
    localparam logic [6:0] OP_BINARY = 7'h02;
    localparam logic [6:0] OP_CLOSE  = 7'h08;
    localparam logic [6:0] OP_PING   = 7'h09;
    localparam logic [6:0] OP_PONG   = 7'h0A;

    localparam logic [15:0] CLOSE_NORMAL    = 16'd1000;
    localparam logic [15:0] CLOSE_PROTOCOL  = 16'd1002;
    localparam logic [15:0] CLOSE_BAD_DATA  = 16'd1003;
    localparam logic [15:0] CLOSE_TOO_BIG   = 16'd1009;

    localparam logic [6:0]  LEN_EXT16       = 7'd126;
    localparam logic [6:0]  LEN_EXT64       = 7'd127;
    localparam logic [15:0] CTRL_MAX_LEN    = 16'd125;
    localparam logic [16:0] HDR_ALLOWANCE   = 17'd8;

    localparam int          CFG_IDX_W       = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DATA_KIND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_FRAME = 8'd1;

    localparam logic [1:0]  DATA_KIND_RESET = 2'd1;
    localparam logic [16:0] MAX_FRAME_RESET = 17'd65536;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] close_code;
        logic        frame_last;
    } result_t;

endpackage

`default_nettype wire

// File: design/wsfr_parser.sv
// ----------------------------------------------------------------------------
// wsfr_parser
// Header parser, unmasking and close decision; one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_parser
    import wsfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [1:0]  accepted_data_kind,
    input  wire logic [16:0] max_frame_total,
    output result_t          result
);

    phase_t      phase_reg, phase_next;
    logic [6:0]  opcode_reg, opcode_next;
    logic        fin_reg, fin_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] peer_reg, peer_next;
    logic        stopped_reg, stopped_next;

    logic [15:0] len16;
    logic [16:0] pos_inc;
    logic [7:0]  key_byte;
    logic [7:0]  unmasked;
    logic        pay_last;
    result_t     res;

    assign len16   = {len_reg[15:8], rx_byte};
    assign pos_inc = {1'b0, pos_reg} + 17'd1;

    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign unmasked = rx_byte ^ key_byte;
    assign pay_last = pos_inc >= {1'b0, len_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        fin_next     = fin_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        peer_next    = peer_reg;
        stopped_next = stopped_reg;
        res          = '0;

        if (step && !stopped_reg)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = rx_byte[6:0];
                    fin_next    = rx_byte[7];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (!rx_byte[7])
                    begin
                        res = '{1'b1, KIND_CLOSE, 8'd0, CLOSE_PROTOCOL, 1'b1};
                    end
                    else if (rx_byte[6:0] == LEN_EXT64)
                    begin
                        res = '{1'b1, KIND_CLOSE, 8'd0, CLOSE_TOO_BIG, 1'b1};
                    end
                    else if (rx_byte[6:0] == LEN_EXT16)
                    begin
                        phase_next = PH_LENHI;
                    end
                    else
                    begin
                        len_next   = {9'd0, rx_byte[6:0]};
                        pos_next   = '0;
                        phase_next = PH_MASK;
                    end
                end
                PH_LENHI:
                begin
                    len_next   = {rx_byte, 8'd0};
                    phase_next = PH_LENLO;
                end
                PH_LENLO:
                begin
                    len_next = len16;
                    if (len16 < {9'd0, LEN_EXT16})
                    begin
                        res = '{1'b1, KIND_CLOSE, 8'd0, CLOSE_PROTOCOL, 1'b1};
                    end
                    else if ({1'b0, len16} + HDR_ALLOWANCE > max_frame_total)
                    begin
                        res = '{1'b1, KIND_CLOSE, 8'd0, CLOSE_TOO_BIG, 1'b1};
                    end
                    else
                    begin
                        pos_next   = '0;
                        phase_next = PH_MASK;
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    pos_next = pos_inc[15:0];
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        // header complete: judge the frame
                        pos_next   = '0;
                        phase_next = PH_PAYLOAD;
                        if (opcode_reg[6:3] != 4'd0 && (!fin_reg || len_reg > CTRL_MAX_LEN))
                        begin
                            res = '{1'b1, KIND_CLOSE, 8'd0, CLOSE_TOO_BIG, 1'b1};
                        end
                        else
                        begin
                            case (opcode_reg)
                                OP_PING:
                                begin
                                    if (len_reg == '0)
                                    begin
                                        phase_next = PH_HDR0;
                                        res = '{1'b1, KIND_PONG_EMPTY, 8'd0, 16'd0, 1'b1};
                                    end
                                end
                                OP_TEXT, OP_BINARY:
                                begin
                                    if (opcode_reg != {5'd0, accepted_data_kind})
                                    begin
                                        res = '{1'b1, KIND_CLOSE, 8'd0, CLOSE_BAD_DATA, 1'b1};
                                    end
                                    else if (len_reg == '0)
                                    begin
                                        phase_next = PH_HDR0;
                                    end
                                end
                                OP_CONT, OP_PONG:
                                begin
                                    if (len_reg == '0)
                                    begin
                                        phase_next = PH_HDR0;
                                    end
                                end
                                OP_CLOSE:
                                begin
                                    peer_next = '0;
                                    if (len_reg == '0)
                                    begin
                                        res = '{1'b1, KIND_CLOSE, 8'd0, CLOSE_NORMAL, 1'b1};
                                    end
                                end
                                default:
                                begin
                                    res = '{1'b1, KIND_CLOSE, 8'd0, CLOSE_PROTOCOL, 1'b1};
                                end
                            endcase
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    pos_next = pos_inc[15:0];
                    if (pay_last)
                    begin
                        phase_next = PH_HDR0;
                    end
                    case (opcode_reg)
                        OP_PING:
                        begin
                            res = '{1'b1, KIND_PONG, unmasked, 16'd0, pay_last};
                        end
                        OP_CONT, OP_TEXT, OP_BINARY:
                        begin
                            res = '{1'b1, KIND_DATA, unmasked, 16'd0, pay_last};
                        end
                        OP_CLOSE:
                        begin
                            if (pos_reg == 16'd0)
                            begin
                                peer_next = {unmasked, 8'd0};
                            end
                            else if (pos_reg == 16'd1)
                            begin
                                peer_next = {peer_reg[15:8], unmasked};
                            end
                            if (pay_last)
                            begin
                                res = '{1'b1, KIND_CLOSE, 8'd0,
                                        (len_reg >= 16'd2) ? peer_next : CLOSE_NORMAL, 1'b1};
                            end
                        end
                        default:
                        begin
                            res = '0;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            if (res.valid && res.kind == KIND_CLOSE)
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= '0;
            fin_reg     <= 1'b0;
            len_reg     <= '0;
            key_reg     <= '0;
            pos_reg     <= '0;
            peer_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            fin_reg     <= fin_next;
            len_reg     <= len_next;
            key_reg     <= key_next;
            pos_reg     <= pos_next;
            peer_reg    <= peer_next;
            stopped_reg <= stopped_next;
        end
    end

    assign result = res;

endmodule

`default_nettype wire

// File: design/websocket_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver_unit
// Client-to-server WebSocket frame receiver: parses headers, unmasks payload,
// answers pings and decides close requests.
//
// Usage:
//   s_axis carries received frame bytes, one item per byte (tdata = rx_byte).
//   m_axis carries results: tuser = kind, tdata = {close_code, value},
//   tlast = last result of the current frame. Not every byte gives a result.
//   cfg writes accepted_data_kind (index 0) and max_frame_total (index 1);
//   cfg_ready is always high; user makes writes while block is idle (not enforced).
// Timing:
//   One byte accepted per clock while the output is not stalled. A byte is
//   registered at its handshake, parsed once the output register is free, and
//   its result lands in the output register. Rate is set by the parse step.
// Reset: parser waits for the first header byte, registers take their
//   defaults, both item registers are empty.
// Stall: while m_axis_tready is low and a result waits, the pending input
//   byte is held and s_axis_tready drops once the input register is full.
//   After a close request all further bytes are taken and dropped until reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_receiver_unit_defines.svh"

module websocket_frame_receiver_unit
    import wsfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [23:0]               m_axis_tdata,   // [7:0] value, [23:8] close_code
    output logic                      m_axis_tlast,
    output logic [1:0]                m_axis_tuser,   // [1:0] kind
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [16:0]          cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        out_last_reg;
    logic [1:0]  out_kind_reg;
    logic [1:0]  data_kind_reg;
    logic [16:0] max_frame_reg;
    logic        out_free;
    logic        step;
    result_t     res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    wsfr_parser u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .rx_byte            (in_byte_reg),
        .accepted_data_kind (data_kind_reg),
        .max_frame_total    (max_frame_reg),
        .result             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            data_kind_reg <= DATA_KIND_RESET;
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= step && res.valid;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IDX_DATA_KIND)
                begin
                    data_kind_reg <= cfg_data[1:0];
                end
                else if (cfg_index == CFG_IDX_MAX_FRAME)
                begin
                    max_frame_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step && res.valid)
        begin
            out_data_reg <= {res.close_code, res.value};
            out_last_reg <= res.frame_last;
            out_kind_reg <= res.kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_kind_reg;

    // nothing follows a close request
    `WSFR_ASSERT_MSG(a_silent_after_close,
        (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_CLOSE) |=> !m_axis_tvalid,
        "wsfr: result after close request")

    // payload results carry no close code
    `WSFR_ASSERT(a_payload_no_code,
        (m_axis_tvalid && (m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_PONG))
            |-> (m_axis_tdata[23:8] == 16'd0))

    // close and empty pong end the frame and carry no byte
    `WSFR_ASSERT(a_ctrl_result_shape,
        (m_axis_tvalid && (m_axis_tuser == KIND_CLOSE || m_axis_tuser == KIND_PONG_EMPTY))
            |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'd0))

endmodule

`default_nettype wire
